FILE: sv/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared constants and types for the table linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int CNT_W       = 9;
  localparam int IDX_W       = 8;

  // func codes
  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;

  // status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_ORDER   = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_FEW     = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  // back-end operations
  localparam logic [1:0] OP_PASS   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic [2:0]        status;
    logic [CNT_W-1:0]  count;
  } tli_cmd_t;

endpackage

`default_nettype wire

FILE: sv/tli_front.sv
// ----------------------------------------------------------------------------
// tli_front
// Accepts words, tracks point count and end keys, classifies each word.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] point_value,
  input  wire logic               q_full,
  output logic                    push,
  output tli_pkg::tli_cmd_t       push_cmd
);
  import tli_pkg::*;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic signed [31:0] first_key;
  logic signed [31:0] last_key;
  logic [15:0]        tol;
  logic               app_ok;
  logic signed [33:0] key_x;
  logic signed [33:0] last_hi;
  logic signed [33:0] first_lo;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign key_x    = {{2{key[31]}}, key};
  assign last_hi  = {{2{last_key[31]}}, last_key} + $signed({18'b0, tol});
  assign first_lo = {{2{first_key[31]}}, first_key} - $signed({18'b0, tol});

  always_comb begin
    push_cmd.op     = OP_PASS;
    push_cmd.key    = key;
    push_cmd.value  = point_value;
    push_cmd.status = ST_DONE;
    count_next      = count;
    app_ok          = 1'b0;
    case (func)
      FN_CLEAR: begin
        count_next      = '0;
        push_cmd.status = ST_CLEARED;
      end
      FN_APPEND: begin
        if (count == CNT_W'(TABLE_DEPTH)) begin
          push_cmd.status = ST_FULL;
        end else if (count != '0 && key_x <= last_hi) begin
          push_cmd.status = ST_ORDER;
        end else begin
          push_cmd.op = OP_APPEND;
          count_next  = count + 1'b1;
          app_ok      = 1'b1;
        end
      end
      FN_QUERY: begin
        if (count < CNT_W'(2)) begin
          push_cmd.status = ST_FEW;
        end else if (key_x < first_lo || key_x > last_hi) begin
          push_cmd.status = ST_RANGE;
        end else begin
          push_cmd.op = OP_QUERY;
        end
      end
      default: begin
      end
    endcase
    push_cmd.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      tol   <= '0;
    end else begin
      if (cfg_we) begin
        tol <= cfg_wdata;
      end
      if (push) begin
        count <= count_next;
      end
    end
  end

  // end keys: payload, only read while count covers them
  always_ff @(posedge clk) begin
    if (push && app_ok) begin
      last_key <= key;
      if (count == '0) begin
        first_key <= key;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/tli_queue.sv
// ----------------------------------------------------------------------------
// tli_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tli_pkg::tli_cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   cmd_valid,
  output tli_pkg::tli_cmd_t      cmd
);
  import tli_pkg::*;

  tli_cmd_t   entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full      = fill == 2'd2;
  assign cmd_valid = fill != 2'd0;
  assign cmd       = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tli_back.sv
// ----------------------------------------------------------------------------
// tli_back
// Point memories, binary search, serial multiply/divide, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire tli_pkg::tli_cmd_t  cmd,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      interpolated,
  output logic [2:0]              status,
  output logic [8:0]              point_count
);
  import tli_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROBE = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_F0    = 4'd3;
  localparam logic [3:0] S_F1    = 4'd4;
  localparam logic [3:0] S_F2    = 4'd5;
  localparam logic [3:0] S_M0    = 4'd6;
  localparam logic [3:0] S_M1    = 4'd7;
  localparam logic [3:0] S_M2    = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic signed [31:0] key_mem [TABLE_DEPTH];
  logic signed [31:0] val_mem [TABLE_DEPTH];
  logic signed [31:0] rd_key;
  logic signed [31:0] rd_val;
  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   waddr;

  logic [3:0]         state;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   kclamp;
  logic [IDX_W-1:0]   idx;
  logic signed [31:0] q;
  logic signed [31:0] k0;
  logic signed [31:0] v0;
  logic signed [32:0] df;
  logic [32:0]        dmag;
  logic [31:0]        dfmag;
  logic [31:0]        dz;
  logic               neg;
  logic [48:0]        pp_lo;
  logic [47:0]        pp_hi;
  logic [48:0]        acc;
  logic [47:0]        acc_hi;
  logic [63:0]        num;
  logic [31:0]        rem;
  logic [32:0]        rem2;
  logic               ge;
  logic [39:0]        qsh;
  logic [5:0]         step;
  logic signed [41:0] r;
  logic signed [31:0] res;
  logic               out_free;
  logic               load;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && cmd_valid && out_free;
  assign load     = (pop && cmd.op != OP_QUERY) || (state == S_FIN && out_free);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign waddr   = IDX_W'(cmd.count - 1'b1);

  always_comb begin
    case (state)
      S_F0:    raddr = idx - 1'b1;
      S_F1:    raddr = idx;
      default: raddr = mid[IDX_W-1:0];
    endcase
  end

  // first key not below q, clamped to 1..cnt-1
  always_comb begin
    if (lo == '0) begin
      kclamp = CNT_W'(1);
    end else if (lo > cnt - 1'b1) begin
      kclamp = cnt - 1'b1;
    end else begin
      kclamp = lo;
    end
  end

  assign df    = {rd_val[31], rd_val} - {v0[31], v0};
  assign pp_lo = dfmag * dmag[16:0];
  assign pp_hi = dfmag * dmag[32:17];
  assign rem2  = {rem, qsh[39]};
  assign ge    = rem2 >= {1'b0, dz};
  assign r     = neg ? ({{10{v0[31]}}, v0} - $signed({2'b0, qsh}))
                     : ({{10{v0[31]}}, v0} + $signed({2'b0, qsh}));

  always_ff @(posedge clk) begin
    if (pop && cmd.op == OP_APPEND) begin
      key_mem[waddr] <= cmd.key;
      val_mem[waddr] <= cmd.value;
    end
    rd_key <= key_mem[raddr];
    rd_val <= val_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop && cmd.op == OP_QUERY) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: state <= (lo == hi) ? S_F0 : S_CMP;
        S_CMP:   state <= S_PROBE;
        S_F0:    state <= S_F1;
        S_F1:    state <= S_F2;
        S_F2:    state <= S_M0;
        S_M0:    state <= S_M1;
        S_M1:    state <= S_M2;
        S_M2:    state <= S_CHK;
        S_CHK: begin
          state <= ({8'b0, num} >= {dz, 40'b0}) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (step == 6'd39) begin
            state <= S_SUM;
          end
        end
        S_SUM: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q   <= cmd.key;
        cnt <= cmd.count;
        lo  <= '0;
        hi  <= cmd.count;
      end
      S_PROBE: idx <= kclamp[IDX_W-1:0];
      S_CMP: begin
        if (rd_key < q) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      S_F1: begin
        k0 <= rd_key;
        v0 <= rd_val;
      end
      S_F2: begin
        // rd_key/rd_val hold the upper point here
        dz    <= rd_key - k0;
        dfmag <= df[32] ? 32'(-df) : df[31:0];
        dmag  <= (q < k0) ? ({k0[31], k0} - {q[31], q}) : ({q[31], q} - {k0[31], k0});
        neg   <= (q < k0) != df[32];
      end
      S_M0: acc    <= pp_lo;
      S_M1: acc_hi <= pp_hi;
      S_M2: begin
        // 64-bit wrapping product plus half divisor
        num <= {15'b0, acc} + {acc_hi[46:0], 17'b0} + {33'b0, dz[31:1]};
      end
      S_CHK: begin
        res  <= neg ? SAT_MIN : SAT_MAX;
        rem  <= {8'b0, num[63:40]};
        qsh  <= num[39:0];
        step <= '0;
      end
      S_DIV: begin
        rem  <= ge ? 32'(rem2 - {1'b0, dz}) : rem2[31:0];
        qsh  <= {qsh[38:0], ge};
        step <= step + 1'b1;
      end
      S_SUM: begin
        if (r > 42'sd2147483647) begin
          res <= SAT_MAX;
        end else if (r < -42'sd2147483648) begin
          res <= SAT_MIN;
        end else begin
          res <= r[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (state == S_FIN) begin
        interpolated <= res;
        status       <= ST_DONE;
        point_count  <= cnt;
      end else begin
        interpolated <= '0;
        status       <= cmd.status;
        point_count  <= cmd.count;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/table_linear_interpolator.sv
// Clear, append, rejected and unused words: output register loaded on pop.
// Query: binary-search probes (PROBE/CMP, up to 9 probes over 256 points),
// then fetch (F0-F2), multiply (M0-M2), check, divide and sum states;
// a saturating quotient skips the divide and sum.
// One query in flight at a time; the 2-word queue lets the front keep taking.
// Reset: count, tolerance and handshake state cleared; memories not cleared.
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a table of Q16.16 points.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_interpolator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] point_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      interpolated,
  output logic [2:0]              status,
  output logic [8:0]              point_count
);
  import tli_pkg::*;

  tli_cmd_t push_cmd;
  tli_cmd_t cmd;
  logic     push;
  logic     q_full;
  logic     pop;
  logic     cmd_valid;

  tli_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key         (key),
    .point_value (point_value),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  tli_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  tli_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .interpolated (interpolated),
    .status       (status),
    .point_count  (point_count)
  );

endmodule

`default_nettype wire

FILE: tb/tb_table_linear_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_table_linear_interpolator
// Self-checking bench: directed table of words, then random clear/append/
// query phases under several tolerances, checked against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_table_linear_interpolator;
  import tli_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct {
    logic signed [31:0] interp;
    logic [2:0]         status;
    logic [8:0]         cnt;
  } tli_result_t;

  typedef struct {
    logic [1:0]         f;
    logic signed [31:0] k;
    logic signed [31:0] v;
    bit                 typed;
    tli_result_t        res;
  } dir_row_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [15:0]        cfg_wdata = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         func = 0;
  logic signed [31:0] key = 0;
  logic signed [31:0] point_value = 0;
  logic               out_valid;
  logic               out_stall = 1;
  logic signed [31:0] interpolated;
  logic [2:0]         status;
  logic [8:0]         point_count;

  // predictor state
  longint      tab_key [TABLE_DEPTH];
  longint      tab_val [TABLE_DEPTH];
  int          tab_cnt = 0;
  longint      tol_reg = 0;

  tli_result_t pending_q[$];
  int          mismatches = 0;
  bit          idle_on = 1;
  bit          hold_req = 0;

  table_linear_interpolator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .key(key),
    .point_value(point_value), .out_valid(out_valid), .out_stall(out_stall),
    .interpolated(interpolated), .status(status), .point_count(point_count)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic logic signed [31:0] lerp(longint q, int i);
    longint d, dz, df, res;
    bit [63:0] ud, udf, udz, prod, quo;
    bit neg;
    d  = q - tab_key[i-1];
    dz = tab_key[i] - tab_key[i-1];
    df = tab_val[i] - tab_val[i-1];
    ud  = (d < 0) ? -d : d;
    udf = (df < 0) ? -df : df;
    udz = dz;
    prod = ud * udf;   // wraps at 64 bits
    quo = (prod + udz / 2) / udz;
    neg = (d < 0) != (df < 0);
    if (quo >= (64'd1 << 40)) return neg ? SAT_MIN : SAT_MAX;
    res = neg ? tab_val[i-1] - longint'(quo) : tab_val[i-1] + longint'(quo);
    if (res > 64'sd2147483647) return SAT_MAX;
    if (res < -64'sd2147483648) return SAT_MIN;
    return res[31:0];
  endfunction

  function automatic tli_result_t apply_word(logic [1:0] f, logic signed [31:0] k,
                                             logic signed [31:0] v);
    tli_result_t r;
    longint q;
    int i;
    r.interp = '0;
    r.status = ST_DONE;
    q = longint'(k);
    case (f)
      FN_CLEAR: begin
        tab_cnt = 0;
        r.status = ST_CLEARED;
      end
      FN_APPEND: begin
        if (tab_cnt >= TABLE_DEPTH) r.status = ST_FULL;
        else if (tab_cnt > 0 && q <= tab_key[tab_cnt-1] + tol_reg) r.status = ST_ORDER;
        else begin
          tab_key[tab_cnt] = q;
          tab_val[tab_cnt] = longint'(v);
          tab_cnt++;
        end
      end
      FN_QUERY: begin
        if (tab_cnt < 2) r.status = ST_FEW;
        else if (q < tab_key[0] - tol_reg || q > tab_key[tab_cnt-1] + tol_reg)
          r.status = ST_RANGE;
        else begin
          i = 0;
          while (i < tab_cnt && tab_key[i] < q) i++;
          if (i < 1) i = 1;
          if (i > tab_cnt - 1) i = tab_cnt - 1;
          r.interp = lerp(q, i);
        end
      end
      default: ;
    endcase
    r.cnt = 9'(tab_cnt);
    return r;
  endfunction

  // Drive one word; returns at the edge where it was taken. Valid stays high.
  task automatic send_word(logic [1:0] f, logic signed [31:0] k, logic signed [31:0] v,
                           bit typed = 0, tli_result_t typed_res = '{0, 0, 0});
    tli_result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    key <= k;
    point_value <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
    r = apply_word(f, k, v);
    pending_q.insert(pending_q.size(), typed ? typed_res : r);
  endtask

  task automatic write_tolerance(logic [15:0] t);
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 0;
    tol_reg = t;
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom;
  endfunction

  // result side: random stall bursts, one long hold on request
  initial begin
    int burst, hold;
    tli_result_t e;
    burst = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: interp=%h status=%0d count=%0d",
                     interpolated, status, point_count);
        end else begin
          e = pending_q.pop_front();
          if (e.interp !== interpolated || e.status !== status || e.cnt !== point_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp interp=%h status=%0d count=%0d, got %h %0d %0d",
                       e.interp, e.status, e.cnt, interpolated, status, point_count);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14) - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("table_linear_interpolator verification failed");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    logic [15:0] tols[6];
    longint lo, hi, nxt, span;
    int npts, nq, sel;
    rows = '{
      '{FN_QUERY,  0, 0, 1, '{0, ST_FEW, 0}},
      '{FN_APPEND, 0, 0, 1, '{0, ST_DONE, 1}},
      '{FN_QUERY,  0, 0, 1, '{0, ST_FEW, 1}},
      '{FN_APPEND, 0, 5, 1, '{0, ST_ORDER, 1}},
      '{FN_APPEND, 32'sh10000, 32'sh10000, 1, '{0, ST_DONE, 2}},
      '{FN_QUERY,  32'sh8000, 0, 1, '{32'sh8000, ST_DONE, 2}},
      '{FN_QUERY,  32'sh20000, 0, 1, '{0, ST_RANGE, 2}},
      '{FN_QUERY,  -1, 0, 1, '{0, ST_RANGE, 2}},
      '{FN_UNUSED, 32'sh7fffffff, 32'sh80000000, 1, '{0, ST_DONE, 2}},
      '{FN_CLEAR,  0, 0, 1, '{0, ST_CLEARED, 0}},
      '{FN_APPEND, 32'sh80000000, 32'sh80000000, 1, '{0, ST_DONE, 1}},
      '{FN_APPEND, 32'sh7fffffff, 32'sh7fffffff, 1, '{0, ST_DONE, 2}},
      '{FN_QUERY,  32'sh80000000, 0, 1, '{32'sh80000000, ST_DONE, 2}},
      '{FN_QUERY,  32'sh7fffffff, 0, 0, '{0, 0, 0}},
      '{FN_QUERY,  0, 0, 0, '{0, 0, 0}},
      '{FN_APPEND, 32'sh7fffffff, 0, 1, '{0, ST_ORDER, 2}},
      '{FN_CLEAR,  0, 0, 1, '{0, ST_CLEARED, 0}},
      '{FN_APPEND, 0, 32'sh7fffffff, 0, '{0, 0, 0}},
      '{FN_APPEND, 1, 32'sh80000000, 0, '{0, 0, 0}},
      '{FN_QUERY,  1, 0, 0, '{0, 0, 0}},
      '{FN_QUERY,  0, 0, 0, '{0, 0, 0}},
      '{FN_APPEND, 2, 32'sh7fffffff, 0, '{0, 0, 0}},
      '{FN_QUERY,  1, 0, 0, '{0, 0, 0}}
    };
    tols = '{16'hffff, 16'h0, 16'h0, 16'h1234, 16'hffff, 16'h0};
    tols[2] = 16'($urandom);
    tols[5] = 16'($urandom);
    repeat (6) @(posedge clk);
    rst <= 0;

    foreach (rows[r]) send_word(rows[r].f, rows[r].k, rows[r].v, rows[r].typed, rows[r].res);

    for (int ph = 0; ph < 6; ph++) begin
      write_tolerance(tols[ph]);
      if (ph == 5) idle_on = 0;
      send_word(FN_CLEAR, rand_word(), rand_word());
      // in phase 1 the fill runs the table past full
      npts = (ph == 1) ? 262 : $urandom_range(2, 24);
      lo = (ph == 1) ? -64'sd2147483648 + $urandom_range(0, 1000)
                     : longint'(rand_word()) / 2 - 64'sd1073741824;
      nxt = lo;
      for (int n = 0; n < npts; n++) begin
        if (n > 0 && ph != 1 && $urandom_range(0, 9) == 0) begin
          // order violation: key within tolerance of the last one
          send_word(FN_APPEND, tab_key[tab_cnt-1] + $urandom_range(0, tol_reg), rand_word());
          continue;
        end
        if (nxt > 64'sd2147483647) break;
        send_word(FN_APPEND, nxt, rand_word());
        nxt = (tab_cnt > 0 ? tab_key[tab_cnt-1] : nxt) + tol_reg + 1 +
              ((ph == 1) ? $urandom_range(0, 4096)
                         : $urandom_range(0, $urandom_range(0, 1) ? 255 : 32'h0fffffff));
      end
      if (ph == 2) hold_req = 1;
      nq = (ph == 1) ? 40 : 70;
      for (int n = 0; n < nq; n++) begin
        sel = $urandom_range(0, 9);
        if (tab_cnt < 2 || sel == 0) begin
          send_word($urandom_range(0, 3), rand_word(), rand_word());
        end else if (sel <= 5) begin
          lo = tab_key[0] - tol_reg;
          hi = tab_key[tab_cnt-1] + tol_reg;
          span = hi - lo + 1;
          send_word(FN_QUERY, lo + longint'({$urandom, $urandom} % span), rand_word());
        end else if (sel <= 7) begin
          send_word(FN_QUERY, tab_key[$urandom_range(0, tab_cnt-1)], rand_word());
        end else begin
          send_word(FN_QUERY, rand_word(), rand_word());
        end
      end
    end

    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("table_linear_interpolator verification clean");
    else
      $display("table_linear_interpolator verification failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/tli_pkg.sv
sv/tli_front.sv
sv/tli_queue.sv
sv/tli_back.sv
sv/table_linear_interpolator.sv
tb/tb_table_linear_interpolator.sv
